>>> src/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ARENA_BASE  = 2'd0,
      REG_ARENA_BYTES = 2'd1,
      REG_LARGE_THR   = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_idx_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [31:0] ARENA_BYTES_RST = 32'd16777216;
   localparam logic [31:0] LARGE_THR_RST   = 32'd8 * 32'd1024 * 32'd1024;

   // shared adder/comparator request and result
   typedef struct packed {
      logic        sub;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        eq;
      logic        ge;
      logic        gt;
   } alu_rsp_type;

endpackage
`default_nettype wire

>>> src/ffba_req_if.sv
// Request channel: operation, size and address to free.
`default_nettype none
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [30:0] request_size;
   logic [31:0] block_address;

   modport source (output valid, op, request_size, block_address, input ready);
   modport sink   (input valid, op, request_size, block_address, output ready);
endinterface
`default_nettype wire

>>> src/ffba_rsp_if.sv
// Response channel: result address, status and usage counters.
`default_nettype none
interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_address;
   logic        success;
   logic [31:0] bytes_in_use;
   logic [31:0] peak_bytes;

   modport source (output valid, result_address, success, bytes_in_use, peak_bytes,
                   input ready);
   modport sink   (input valid, result_address, success, bytes_in_use, peak_bytes,
                   output ready);
endinterface
`default_nettype wire

>>> src/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

>>> src/ffba_alu.sv
// Shared 32-bit three-input adder/subtractor with compare against a separate operand d.
`default_nettype none
module ffba_alu
   import ffba_pkg::*;
(
   input  wire alu_req_type req,
   output alu_rsp_type      rsp
);
   logic [33:0] add_w;

   always_comb begin
      add_w   = {2'b00, req.a} + {2'b00, req.b} + {2'b00, req.c};
      rsp.sum = req.sub ? (req.a - req.b) : add_w[31:0];
      rsp.eq  = (rsp.sum == req.d);
      rsp.ge  = (add_w >= {2'b00, req.d});
      rsp.gt  = (add_w >  {2'b00, req.d});
   end
endmodule
`default_nettype wire

>>> src/first_fit_block_allocator.sv
// Top level: first-fit allocator sequencer with free and used block tables.
//
//  channel | direction | handshake          | payload
//  req     | in        | valid/ready        | op, request_size, block_address
//  rsp     | out       | valid/ready        | result_address, success, usage, peak
//  csr     | in        | APB write, pready=1| arena_base, arena_bytes, large_threshold
//
// Table entries are visited one at a time, paced by the one read port of each
// table RAM and the shared adder; a free runs merge, lookup, shift, position
// search and shift in turn. One request is in flight at a time; req.ready is
// high only when idle. A finished result sits in the output register until
// taken, while the next request may already be accepted; a second result
// waits in S_DONE. Synchronous reset clears counts and flags; table contents
// are not cleared.
`default_nettype none
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64,
   parameter int HEADER_BYTES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ffba_req_if.sink                   req_if,
   ffba_rsp_if.source                 rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
   localparam logic [31:0]   HDR     = 32'(HEADER_BYTES);

   typedef enum logic [4:0] {
      S_IDLE, S_A_RD, S_A_CHK, S_A_SUB, S_A_ADD, S_A_SH_RD, S_A_SH_WR, S_A_REC,
      S_A_PEAK, S_A_LARGE, S_M_FRD, S_M_FIRST, S_M_RD, S_M_CHK, S_M_ADD, S_M_END,
      S_L_RD, S_L_CHK, S_U_SH_RD, S_U_SH_WR, S_U_TOT, S_P_RD, S_P_CHK,
      S_F_SH_RD, S_F_SH_WR, S_F_INS, S_DONE
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [31:0] arena_base_ff, arena_bytes_ff, large_thr_ff;

   // allocator state
   logic [CW-1:0] free_cnt_ff, used_cnt_ff, i_ff, w_ff, pos_ff;
   logic [31:0]   total_ff, peak_ff, large_addr_ff;
   logic          large_valid_ff, arena_ready_ff;

   // request working registers
   logic [30:0]   size_ff;
   logic [31:0]   addr_ff, need_ff, cur_start_ff, cur_size_ff, tmp_ff, blk_start_ff;
   logic [31:0]   res_addr_ff;
   logic          ok_ff;

   // output register
   logic          rsp_valid_ff;
   logic [31:0]   rsp_addr_ff, rsp_total_ff, rsp_peak_ff;
   logic          rsp_ok_ff;

   // table RAM ports
   logic          fr_we, us_we;
   logic [AW-1:0] fr_waddr, fr_raddr, us_waddr, us_raddr;
   logic [63:0]   fr_wdata, fr_rdata, us_wdata, us_rdata;

   alu_req_type   alu_req;
   alu_rsp_type   alu_rsp;

   logic [CW-1:0] ip1, im1;
   logic          csr_wr;
   logic [31:0]   init_size;

   assign ip1        = i_ff + 1'b1;
   assign im1        = i_ff - 1'b1;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign init_size  = (arena_bytes_ff >= HDR) ? (arena_bytes_ff - HDR) : 32'd0;

   assign req_if.ready          = (state_ff == S_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result_address = rsp_addr_ff;
   assign rsp_if.success        = rsp_ok_ff;
   assign rsp_if.bytes_in_use   = rsp_total_ff;
   assign rsp_if.peak_bytes     = rsp_peak_ff;

   always_comb begin
      unique case (reg_idx_type'(csr_paddr[3:2]))
         REG_ARENA_BASE:  csr_prdata = arena_base_ff;
         REG_ARENA_BYTES: csr_prdata = arena_bytes_ff;
         REG_LARGE_THR:   csr_prdata = large_thr_ff;
         default:         csr_prdata = '0;
      endcase
   end

   ffba_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_free_ram (
      .clock(clock), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
      .raddr(fr_raddr), .rdata(fr_rdata)
   );

   ffba_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_used_ram (
      .clock(clock), .we(us_we), .waddr(us_waddr), .wdata(us_wdata),
      .raddr(us_raddr), .rdata(us_rdata)
   );

   ffba_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   // operand selection for the shared adder/comparator
   always_comb begin
      alu_req = '0;
      unique case (state_ff)
         S_A_CHK: begin   // fit: size >= need, exact when equal
            alu_req.a = fr_rdata[31:0];
            alu_req.d = need_ff;
         end
         S_A_SUB: begin
            alu_req.sub = 1'b1;
            alu_req.a   = cur_size_ff;
            alu_req.b   = need_ff;
         end
         S_A_ADD: begin
            alu_req.a = blk_start_ff;
            alu_req.b = need_ff;
         end
         S_A_REC: begin
            alu_req.a = total_ff;
            alu_req.b = {1'b0, size_ff};
         end
         S_A_PEAK: begin
            alu_req.a = total_ff;
            alu_req.d = peak_ff;
         end
         S_A_LARGE, S_L_CHK: begin
            alu_req.a = (state_ff == S_A_LARGE) ? blk_start_ff : us_rdata[63:32];
            alu_req.b = HDR;
            alu_req.d = addr_ff;
         end
         S_M_CHK: begin   // segment end meets the next start
            alu_req.a = cur_start_ff;
            alu_req.b = HDR;
            alu_req.c = cur_size_ff;
            alu_req.d = fr_rdata[63:32];
         end
         S_M_ADD: begin
            alu_req.a = cur_size_ff;
            alu_req.b = tmp_ff;
            alu_req.c = HDR;
         end
         S_U_TOT: begin
            alu_req.sub = 1'b1;
            alu_req.a   = total_ff;
            alu_req.b   = cur_size_ff;
         end
         S_P_CHK: begin
            alu_req.a = fr_rdata[63:32];
            alu_req.d = blk_start_ff;
         end
         default: alu_req = '0;
      endcase
   end

   // table RAM control
   always_comb begin
      fr_we    = 1'b0;
      fr_waddr = i_ff[AW-1:0];
      fr_wdata = '0;
      fr_raddr = i_ff[AW-1:0];
      us_we    = 1'b0;
      us_waddr = i_ff[AW-1:0];
      us_wdata = '0;
      us_raddr = i_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            fr_waddr = '0;
            fr_wdata = {arena_base_ff, init_size};
            fr_we    = req_if.valid && (req_if.op == OP_ALLOC) && !arena_ready_ff;
         end
         S_A_ADD: begin
            fr_we    = 1'b1;
            fr_wdata = {alu_rsp.sum, cur_size_ff};
         end
         S_A_SH_RD: fr_raddr = ip1[AW-1:0];
         S_A_SH_WR: begin
            fr_we    = 1'b1;
            fr_wdata = fr_rdata;
         end
         S_A_REC: begin
            us_we    = 1'b1;
            us_waddr = used_cnt_ff[AW-1:0];
            us_wdata = {blk_start_ff, 1'b0, size_ff};
         end
         S_M_FRD: fr_raddr = '0;
         S_M_CHK: begin
            fr_we    = !alu_rsp.eq;
            fr_waddr = w_ff[AW-1:0];
            fr_wdata = {cur_start_ff, cur_size_ff};
         end
         S_M_END: begin
            fr_we    = 1'b1;
            fr_waddr = w_ff[AW-1:0];
            fr_wdata = {cur_start_ff, cur_size_ff};
         end
         S_L_RD:    us_raddr = im1[AW-1:0];
         S_U_SH_RD: us_raddr = ip1[AW-1:0];
         S_U_SH_WR: begin
            us_we    = 1'b1;
            us_wdata = us_rdata;
         end
         S_F_SH_RD: fr_raddr = im1[AW-1:0];
         S_F_SH_WR: begin
            fr_we    = 1'b1;
            fr_wdata = fr_rdata;
         end
         S_F_INS: begin
            fr_we    = 1'b1;
            fr_waddr = pos_ff[AW-1:0];
            fr_wdata = {blk_start_ff, cur_size_ff};
         end
         default: ;
      endcase
   end

   // sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         arena_base_ff  <= '0;
         arena_bytes_ff <= ARENA_BYTES_RST;
         large_thr_ff   <= LARGE_THR_RST;
         free_cnt_ff    <= '0;
         used_cnt_ff    <= '0;
         total_ff       <= '0;
         peak_ff        <= '0;
         large_addr_ff  <= '0;
         large_valid_ff <= 1'b0;
         arena_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (reg_idx_type'(csr_paddr[3:2]))
               REG_ARENA_BASE:  arena_base_ff  <= csr_pwdata;
               REG_ARENA_BYTES: arena_bytes_ff <= csr_pwdata;
               REG_LARGE_THR:   large_thr_ff   <= csr_pwdata;
               default: ;
            endcase
         end
         // S_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  size_ff     <= req_if.request_size;
                  addr_ff     <= req_if.block_address;
                  need_ff     <= {1'b0, req_if.request_size} + HDR;
                  res_addr_ff <= '0;
                  ok_ff       <= 1'b0;
                  // lookup starts from the newest block when merging is skipped
                  i_ff        <= (req_if.op == OP_FREE) ? used_cnt_ff : '0;
                  if (req_if.op == OP_ALLOC) begin
                     if (!arena_ready_ff) begin
                        free_cnt_ff    <= CW'(1);
                        arena_ready_ff <= 1'b1;
                     end
                     if (req_if.request_size == '0 || used_cnt_ff >= MAX_CNT) begin
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_A_RD;
                     end
                  end else if (req_if.block_address == '0 ||
                               (large_valid_ff && req_if.block_address > large_addr_ff)) begin
                     state_ff <= S_DONE;
                  end else if (free_cnt_ff == '0) begin
                     state_ff <= S_L_RD;
                  end else begin
                     state_ff <= S_M_FRD;
                  end
               end
            end

            // allocate: first-fit scan
            S_A_RD: state_ff <= (i_ff >= free_cnt_ff) ? S_DONE : S_A_CHK;
            S_A_CHK: begin
               blk_start_ff <= fr_rdata[63:32];
               cur_size_ff  <= fr_rdata[31:0];
               if (alu_rsp.ge) begin
                  state_ff <= alu_rsp.eq ? S_A_SH_RD : S_A_SUB;
               end else begin
                  i_ff     <= ip1;
                  state_ff <= S_A_RD;
               end
            end
            S_A_SUB: begin
               cur_size_ff <= alu_rsp.sum;
               state_ff    <= S_A_ADD;
            end
            S_A_ADD: state_ff <= S_A_REC;
            // exact fit: close the gap in the free table
            S_A_SH_RD: begin
               if (ip1 >= free_cnt_ff) begin
                  free_cnt_ff <= free_cnt_ff - 1'b1;
                  state_ff    <= S_A_REC;
               end else begin
                  state_ff <= S_A_SH_WR;
               end
            end
            S_A_SH_WR: begin
               i_ff     <= ip1;
               state_ff <= S_A_SH_RD;
            end
            S_A_REC: begin
               used_cnt_ff <= used_cnt_ff + 1'b1;
               total_ff    <= alu_rsp.sum;
               state_ff    <= S_A_PEAK;
            end
            S_A_PEAK: begin
               if (alu_rsp.gt) begin
                  peak_ff <= total_ff;
               end
               state_ff <= S_A_LARGE;
            end
            S_A_LARGE: begin
               res_addr_ff <= alu_rsp.sum;
               ok_ff       <= 1'b1;
               if ({1'b0, size_ff} > large_thr_ff) begin
                  large_addr_ff  <= alu_rsp.sum;
                  large_valid_ff <= 1'b1;
               end
               state_ff <= S_DONE;
            end

            // free: merge adjacent segments
            S_M_FRD: state_ff <= S_M_FIRST;
            S_M_FIRST: begin
               cur_start_ff <= fr_rdata[63:32];
               cur_size_ff  <= fr_rdata[31:0];
               w_ff         <= '0;
               i_ff         <= CW'(1);
               state_ff     <= S_M_RD;
            end
            S_M_RD: state_ff <= (i_ff >= free_cnt_ff) ? S_M_END : S_M_CHK;
            S_M_CHK: begin
               if (alu_rsp.eq) begin
                  tmp_ff   <= fr_rdata[31:0];
                  state_ff <= S_M_ADD;
               end else begin
                  w_ff         <= w_ff + 1'b1;
                  cur_start_ff <= fr_rdata[63:32];
                  cur_size_ff  <= fr_rdata[31:0];
                  i_ff         <= ip1;
                  state_ff     <= S_M_RD;
               end
            end
            S_M_ADD: begin
               cur_size_ff <= alu_rsp.sum;
               i_ff        <= ip1;
               state_ff    <= S_M_RD;
            end
            S_M_END: begin
               free_cnt_ff <= w_ff + 1'b1;
               i_ff        <= used_cnt_ff;
               state_ff    <= S_L_RD;
            end

            // free: look up the block, newest first
            S_L_RD: state_ff <= (i_ff == '0) ? S_DONE : S_L_CHK;
            S_L_CHK: begin
               if (alu_rsp.eq) begin
                  blk_start_ff <= us_rdata[63:32];
                  cur_size_ff  <= us_rdata[31:0];
                  i_ff         <= im1;
                  state_ff     <= (free_cnt_ff >= MAX_CNT) ? S_DONE : S_U_SH_RD;
               end else begin
                  i_ff     <= im1;
                  state_ff <= S_L_RD;
               end
            end
            S_U_SH_RD: begin
               if (ip1 >= used_cnt_ff) begin
                  used_cnt_ff <= used_cnt_ff - 1'b1;
                  state_ff    <= S_U_TOT;
               end else begin
                  state_ff <= S_U_SH_WR;
               end
            end
            S_U_SH_WR: begin
               i_ff     <= ip1;
               state_ff <= S_U_SH_RD;
            end
            S_U_TOT: begin
               total_ff <= alu_rsp.sum;
               i_ff     <= '0;
               state_ff <= S_P_RD;
            end

            // free: find the insertion point and open a slot
            S_P_RD: begin
               if (i_ff >= free_cnt_ff) begin
                  pos_ff   <= i_ff;
                  state_ff <= S_F_SH_RD;
               end else begin
                  state_ff <= S_P_CHK;
               end
            end
            S_P_CHK: begin
               if (alu_rsp.gt) begin
                  pos_ff   <= i_ff;
                  i_ff     <= free_cnt_ff;
                  state_ff <= S_F_SH_RD;
               end else begin
                  i_ff     <= ip1;
                  state_ff <= S_P_RD;
               end
            end
            S_F_SH_RD: state_ff <= (i_ff == pos_ff) ? S_F_INS : S_F_SH_WR;
            S_F_SH_WR: begin
               i_ff     <= im1;
               state_ff <= S_F_SH_RD;
            end
            S_F_INS: begin
               free_cnt_ff <= free_cnt_ff + 1'b1;
               ok_ff       <= 1'b1;
               state_ff    <= S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_addr_ff  <= ok_ff ? res_addr_ff : 32'd0;
                  rsp_ok_ff    <= ok_ff;
                  rsp_total_ff <= total_ff;
                  rsp_peak_ff  <= peak_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_free_cnt_max: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= MAX_CNT) else $error("free table count above capacity");

   a_used_cnt_max: assert property (@(posedge clock) disable iff (reset)
      used_cnt_ff <= MAX_CNT) else $error("used table count above capacity");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("new transfer taken while a request is in progress");

   a_arena_sticky: assert property (@(posedge clock) disable iff (reset)
      arena_ready_ff |=> arena_ready_ff) else $error("arena set-up flag dropped");

   a_alloc_sets_arena: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.op == OP_ALLOC) |=> arena_ready_ff)
      else $error("allocate did not set up the arena");

endmodule
`default_nettype wire
